FILE: rtl/core/skm_pkg.sv
// Shared types and constants for the sorted k-mer stream merge.
package skm_pkg;

	localparam int KMER_W   = 64;
	localparam int SRC_W    = 3;
	localparam int MASK_W   = 8;
	localparam int ACTIVE_W = 4;
	localparam int KLEN_W   = 6;
	localparam int CFG_W    = 6;
	localparam int QDEPTH   = 2;
	localparam int QAW      = 1;
	localparam int QCW      = 2;

	typedef enum logic [0:0] {
		REG_ACTIVE_SOURCES = 1'b0,
		REG_KMER_LENGTH    = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_FIN
	} back_state_t;

	typedef struct packed {
		logic [SRC_W-1:0]  src;
		logic              in_range;
		logic              exhausted;
		logic [KMER_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic              emit_valid;
		logic [KMER_W-1:0] merged_kmer;
		logic [MASK_W-1:0] source_mask;
		logic              request_valid;
		logic [SRC_W-1:0]  request_source;
		logic              done_res;
	} res_t;

	function automatic logic [ACTIVE_W-1:0] clamp_count(
		input logic [ACTIVE_W-1:0] a,
		input logic [ACTIVE_W-1:0] lim
	);
		logic [ACTIVE_W-1:0] r;
		r = a;
		if (r == '0) begin
			r = ACTIVE_W'(1);
		end
		if (r > lim) begin
			r = lim;
		end
		return r;
	endfunction

	function automatic logic [KMER_W-1:0] kmer_mask(input logic [KLEN_W-1:0] klen);
		logic [KLEN_W-1:0] k;
		logic [KMER_W-1:0] m;
		k = (klen == '0) ? KLEN_W'(1) : klen;
		if (k >= KLEN_W'(32)) begin
			m = '1;
		end else begin
			m = (KMER_W'(1) << {k, 1'b0}) - KMER_W'(1);
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/sorted_kmer_stream_merge.sv
// Top level of the sorted k-mer stream merge: configuration registers and wiring.
// Merges up to eight ascending k-mer streams into one ascending stream of distinct
// k-mers, each with a mask of the streams that held it. Every input transaction gets
// exactly one output transaction. A transaction that is ignored, or that still leaves
// some stream's head outstanding, is answered from the idle state once it leaves the
// two-entry input queue. The transaction that completes the set of heads starts a
// minimum scan over the N active streams' stored heads, one stream per cycle, and
// then waits for a free output; the scan is what sets the sustained rate. Writing
// active_sources restarts the merge; the user must write it only while the block is
// idle, which the block does not enforce. kmer_length applies to later transactions.
module sorted_kmer_stream_merge import skm_pkg::*; #(
	parameter int MAX_SOURCES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SRC_W-1:0]    source,
	input  logic [KMER_W-1:0]   kmer_value,
	input  logic                exhausted,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                emit_valid,
	output logic [KMER_W-1:0]   merged_kmer,
	output logic [MASK_W-1:0]   source_mask,
	output logic                request_valid,
	output logic [SRC_W-1:0]    request_source,
	output logic                done_res
);

	localparam int LANES = (MAX_SOURCES < 8) ? MAX_SOURCES : 8;
	localparam logic [ACTIVE_W-1:0] LANE_LIM = ACTIVE_W'(LANES);

	logic [ACTIVE_W-1:0] active_q;
	logic [KLEN_W-1:0]   klen_q;
	logic [ACTIVE_W-1:0] live_n;
	logic [ACTIVE_W-1:0] restart_n;
	logic                restart;
	logic                q_full;
	logic                q_push;
	logic                q_pop;
	logic                q_valid;
	item_t               push_item;
	item_t               q_head;
	res_t                res;

	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACTIVE_SOURCES: restart = 1'b1;
				REG_KMER_LENGTH:    restart = 1'b0;
				default:            restart = 1'b0;
			endcase
		end
	end

	assign live_n    = clamp_count(active_q, LANE_LIM);
	assign restart_n = clamp_count(cfg_data[ACTIVE_W-1:0], LANE_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_W'(1);
			klen_q   <= KLEN_W'(32);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACTIVE_SOURCES: active_q <= cfg_data[ACTIVE_W-1:0];
				REG_KMER_LENGTH:    klen_q   <= cfg_data[KLEN_W-1:0];
				default:            ;
			endcase
		end
	end

	skm_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.source     (source),
		.kmer_value (kmer_value),
		.exhausted  (exhausted),
		.kmer_len   (klen_q),
		.live_n     (live_n),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	skm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	skm_back #(
		.LANES (LANES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.restart_n (restart_n),
		.live_n    (live_n),
		.q_valid   (q_valid),
		.q_item    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign emit_valid     = res.emit_valid;
	assign merged_kmer    = res.merged_kmer;
	assign source_mask    = res.source_mask;
	assign request_valid  = res.request_valid;
	assign request_source = res.request_source;
	assign done_res       = res.done_res;

endmodule

FILE: rtl/core/skm_front.sv
// Input side: takes transactions, masks the k-mer and checks the source range.
module skm_front import skm_pkg::*; (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SRC_W-1:0]    source,
	input  logic [KMER_W-1:0]   kmer_value,
	input  logic                exhausted,
	input  logic [KLEN_W-1:0]   kmer_len,
	input  logic [ACTIVE_W-1:0] live_n,
	input  logic                q_full,
	output logic                q_push,
	output item_t               q_item
);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.src       = source;
		q_item.in_range  = ({1'b0, source} < live_n);
		q_item.exhausted = exhausted;
		q_item.value     = kmer_value & kmer_mask(kmer_len);
	end

endmodule

FILE: rtl/core/skm_queue.sv
// Two-entry queue between the input side and the merge engine.
module skm_queue import skm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t head
);

	item_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign full  = (count_q == QCW'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/skm_back.sv
// Merge engine: head store, minimum scan, duplicate union and result register.
module skm_back import skm_pkg::*; #(
	parameter int LANES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  logic [ACTIVE_W-1:0] restart_n,
	input  logic [ACTIVE_W-1:0] live_n,
	input  logic                q_valid,
	input  item_t               q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output res_t                res
);

	localparam int IW = $clog2(LANES);

	back_state_t       state_q, state_nxt;
	logic [KMER_W-1:0] head_q [LANES];
	logic [LANES-1:0]  present_q;
	logic [LANES-1:0]  awaiting_q;
	logic [KMER_W-1:0] cur_q;
	logic              cur_present_q;
	logic [LANES-1:0]  acc_q;
	logic              finished_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     best_q;
	logic [KMER_W-1:0] best_val_q;
	logic              found_q;
	logic              out_valid_q;
	res_t              res_q;

	logic              out_free;
	logic [IW-1:0]     lane;
	logic [LANES-1:0]  lane_bit;
	logic [LANES-1:0]  best_bit;
	logic              wanted;
	logic              others_wait;
	logic              take;
	logic              last_idx;
	logic              ld;
	res_t              res_nxt;

	function automatic logic [LANES-1:0] lane_set(input logic [ACTIVE_W-1:0] n);
		logic [LANES-1:0] m;
		for (int i = 0; i < LANES; i++) begin
			m[i] = (ACTIVE_W'(i) < n);
		end
		return m;
	endfunction

	assign out_free    = !out_valid_q || !out_stall;
	assign lane        = q_item.src[IW-1:0];
	assign lane_bit    = LANES'(1) << lane;
	assign best_bit    = LANES'(1) << best_q;
	assign wanted      = q_item.in_range && !finished_q && awaiting_q[lane];
	assign others_wait = (awaiting_q & ~lane_bit) != '0;
	assign take        = present_q[idx_q] && (!found_q || head_q[idx_q] < best_val_q);
	assign last_idx    = ({{(ACTIVE_W-IW){1'b0}}, idx_q} == live_n - ACTIVE_W'(1));
	assign out_valid   = out_valid_q;
	assign res         = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else if (restart) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		ld        = 1'b0;
		res_nxt   = '0;
		res_nxt.done_res = finished_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (!wanted || others_wait) begin
						ld = 1'b1;
					end else begin
						state_nxt = B_SCAN;
					end
				end
			end
			B_SCAN: begin
				if (last_idx) begin
					state_nxt = B_FIN;
				end
			end
			B_FIN: begin
				if (out_free) begin
					ld        = 1'b1;
					state_nxt = B_IDLE;
					if (!found_q) begin
						res_nxt.emit_valid  = cur_present_q;
						res_nxt.merged_kmer = cur_present_q ? cur_q : '0;
						res_nxt.source_mask = cur_present_q ? MASK_W'(acc_q) : '0;
						res_nxt.done_res    = 1'b1;
					end else begin
						res_nxt.request_valid  = 1'b1;
						res_nxt.request_source = SRC_W'(best_q);
						if (cur_present_q && best_val_q != cur_q) begin
							res_nxt.emit_valid  = 1'b1;
							res_nxt.merged_kmer = cur_q;
							res_nxt.source_mask = MASK_W'(acc_q);
						end
					end
				end
			end
			default: state_nxt = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_pop && wanted && !q_item.exhausted) begin
			head_q[lane] <= q_item.value;
		end
		if (state_q == B_SCAN && take) begin
			best_val_q <= head_q[idx_q];
		end
		if (ld) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q     <= '0;
			awaiting_q    <= lane_set(ACTIVE_W'(1));
			cur_q         <= '0;
			cur_present_q <= 1'b0;
			acc_q         <= '0;
			finished_q    <= 1'b0;
			idx_q         <= '0;
			best_q        <= '0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else if (restart) begin
			present_q     <= '0;
			awaiting_q    <= lane_set(restart_n);
			cur_q         <= '0;
			cur_present_q <= 1'b0;
			acc_q         <= '0;
			finished_q    <= 1'b0;
			idx_q         <= '0;
			found_q       <= 1'b0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (q_pop && wanted) begin
						awaiting_q[lane] <= 1'b0;
						if (!q_item.exhausted) begin
							present_q[lane] <= 1'b1;
						end
					end
				end
				B_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (take) begin
						best_q  <= idx_q;
						found_q <= 1'b1;
					end
				end
				B_FIN: begin
					if (out_free) begin
						if (!found_q) begin
							cur_present_q <= 1'b0;
							acc_q         <= '0;
							finished_q    <= 1'b1;
						end else begin
							present_q  <= present_q & ~best_bit;
							awaiting_q <= awaiting_q | best_bit;
							if (cur_present_q && best_val_q == cur_q) begin
								acc_q <= acc_q | best_bit;
							end else begin
								cur_q         <= best_val_q;
								cur_present_q <= 1'b1;
								acc_q         <= best_bit;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
